// ===== rtl/ntcb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package ntcb_pkg;

  localparam int ADC_BITS = 12;
  localparam int AMAX = (1 << ADC_BITS) - 1;
  localparam int AMAX_HALF = AMAX / 2;

  localparam int DW = ADC_BITS + 15;
  localparam int MW = ADC_BITS + 14;
  localparam int PW = 20 + MW;
  localparam int QW = PW + 1;
  localparam int VW = (MW > 23) ? MW : 23;
  localparam int CW = $clog2(QW);
  localparam int EW = $clog2(MW);
  localparam int LQW = 22;
  localparam int LSW = 25;
  localparam int KNW = 38;

  // The midpoint voltage is rounded by a reciprocal multiplication that is exact
  // for every numerator below 2**MW.
  localparam int VRECIP_SHIFT = MW + ADC_BITS;
  localparam int VPW = 2 * MW + 1;
  localparam longint VRECIP =
    ((longint'(1) <<< VRECIP_SHIFT) + longint'(AMAX) - 1) / longint'(AMAX);

  // The Fahrenheit division by ten is folded into one multiply and add.
  localparam int FRECIP_SHIFT = 24;
  localparam int FPW = 42;
  localparam int FRECIP_K = 30198996;
  localparam int FRECIP_C = 8388610;

  localparam int LN2_Q16 = 45426;
  localparam int K_SCALE = 6553600;
  localparam int KELVIN_MAX = 100000;
  localparam int RES_MAX = 16777215;
  localparam int VIN_MAX = 16383;
  localparam int CELSIUS_OFS = 27315;
  localparam int FAHR_OFS = 45967;

  localparam logic [19:0] RS_RESET = 20'd10000;
  localparam logic [13:0] BETA_RESET = 14'd3950;
  localparam logic signed [21:0] LRI_RESET = -22'sd264641;
  localparam logic [12:0] SUPPLY_RESET = 13'd3300;
  localparam logic [12:0] REF_RESET = 13'd3300;
  localparam logic [12:0] OFS_RESET = 13'd0;

  typedef enum logic [2:0] {
    REG_RS,
    REG_BETA,
    REG_LRI,
    REG_SUPPLY,
    REG_REF,
    REG_OFS,
    REG_GND
  } reg_idx_t;

  typedef struct packed {
    logic [19:0] rs;
    logic [13:0] beta;
    logic signed [21:0] lri;
    logic [12:0] supply;
    logic [12:0] ref_mv;
    logic [12:0] ofs;
    logic gnd;
  } cfg_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_VDIV,
    B_VWAIT,
    B_CLASS,
    B_RMUL,
    B_RDIV,
    B_RWAIT,
    B_LN,
    B_LWAIT,
    B_LCHK,
    B_KMUL,
    B_KDIV,
    B_KWAIT,
    B_FDIV,
    B_FWAIT,
    B_OUT
  } bstate_t;

  function automatic logic [15:0] ln_tab(input logic [4:0] i);
    logic [15:0] v;
    case (i)
      5'd0: v = 16'd0;
      5'd1: v = 16'd3973;
      5'd2: v = 16'd7719;
      5'd3: v = 16'd11262;
      5'd4: v = 16'd14624;
      5'd5: v = 16'd17821;
      5'd6: v = 16'd20870;
      5'd7: v = 16'd23783;
      5'd8: v = 16'd26573;
      5'd9: v = 16'd29248;
      5'd10: v = 16'd31818;
      5'd11: v = 16'd34292;
      5'd12: v = 16'd36675;
      5'd13: v = 16'd38975;
      5'd14: v = 16'd41196;
      5'd15: v = 16'd43345;
      5'd16: v = 16'd45426;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/ntcb_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ntcb_front
  import ntcb_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire cfg_t                 cfg,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [ADC_BITS-1:0]  adc_sample,
  output logic                      q_valid,
  output logic signed [DW-1:0]      q_n,
  input  wire logic                 q_pop
);

  logic signed [DW-1:0] mem [2];
  logic wr_ptr;
  logic rd_ptr;
  logic [1:0] count;
  logic push;
  logic signed [DW-1:0] s_ext;
  logic signed [DW-1:0] diff_ext;
  logic signed [DW-1:0] ofs_ext;
  logic signed [DW-1:0] n_new;

  always_comb begin
    s_ext = DW'(adc_sample);
    ofs_ext = DW'(cfg.ofs);
    diff_ext = DW'(cfg.ref_mv) - ofs_ext;
    n_new = (ofs_ext <<< ADC_BITS) - ofs_ext + s_ext * diff_ext;
  end

  assign in_stall = (count == 2'd2);
  assign push = in_valid && !in_stall;
  assign q_valid = (count != 2'd0);
  assign q_n = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= n_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/ntcb_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ntcb_div
  import ntcb_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [QW-1:0] dividend,
  input  wire logic [VW-1:0] divisor,
  input  wire logic [CW-1:0] msb,
  output logic               done,
  output logic [QW-1:0]      quotient
);

  logic busy;
  logic [CW-1:0] cnt;
  logic [VW-1:0] rem;
  logic [QW-1:0] dvd;
  logic [VW-1:0] dvs;
  logic [VW:0] trial;
  logic fits;

  always_comb begin
    trial = {rem, dvd[cnt]};
    fits = (trial >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt <= msb;
      rem <= '0;
      quotient <= '0;
      dvd <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      if (fits) begin
        rem <= VW'(trial - {1'b0, dvs});
      end else begin
        rem <= trial[VW-1:0];
      end
      quotient <= {quotient[QW-2:0], fits};
      cnt <= cnt - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/ntcb_ln.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ntcb_ln
  import ntcb_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           valid_in,
  input  wire logic [MW-1:0]  x,
  output logic                valid_out,
  output logic [LQW-1:0]      y
);

  logic [EW-1:0] lead;
  logic [EW-1:0] sh;
  logic [MW-1:0] norm;
  logic v1;
  logic [EW-1:0] e1;
  logic [3:0] i1;
  logic [15:0] r1;
  logic [15:0] t_lo;
  logic [15:0] t_hi;
  logic [11:0] diff;
  logic [27:0] prod;
  logic [11:0] frac;

  always_comb begin
    lead = '0;
    for (int k = 0; k < MW; k++) begin
      if (x[k]) begin
        lead = EW'(k);
      end
    end
    sh = EW'(MW - 1) - lead;
    norm = x << sh;
  end

  always_comb begin
    t_lo = ln_tab({1'b0, i1});
    t_hi = ln_tab(5'({1'b0, i1}) + 5'd1);
    diff = 12'(t_hi - t_lo);
    prod = 28'(diff) * 28'(r1);
    frac = 12'((prod + 28'd32768) >> 16);
  end

  always_ff @(posedge clk) begin
    e1 <= lead;
    i1 <= norm[MW-2 -: 4];
    r1 <= norm[MW-6 -: 16];
    y <= LQW'(e1) * LQW'(LN2_Q16) + LQW'(t_lo) + LQW'(frac);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      valid_out <= 1'b0;
    end else begin
      v1 <= valid_in;
      valid_out <= v1;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/ntcb_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ntcb_back
  import ntcb_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cfg_t               cfg,
  input  wire logic               q_valid,
  input  wire logic signed [DW-1:0] q_n,
  output logic                    q_pop,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [13:0]             input_mv,
  output logic [23:0]             resistance_ohms,
  output logic [16:0]             kelvin_centi,
  output logic signed [17:0]      celsius_centi,
  output logic signed [18:0]      fahrenheit_centi,
  output logic                    fault
);

  bstate_t state;
  bstate_t state_next;

  logic signed [DW-1:0] n;
  logic signed [DW-1:0] num;
  logic signed [DW-1:0] den;
  logic [MW-1:0] unum;
  logic [MW-1:0] uden;
  logic [PW-1:0] prod;
  logic signed [LSW-1:0] lsum;
  logic [KNW-1:0] kdvd;
  logic [VPW-1:0] vprod;
  logic [FPW-1:0] fprod;
  logic [13:0] vin;
  logic [23:0] res;
  logic [16:0] kel;
  logic signed [18:0] fah;
  logic flt;
  logic [1:0] ln_idx;
  logic [1:0] ln_got;

  logic signed [DW-1:0] sup_ext;
  logic signed [DW-1:0] d_new;
  logic [MW-1:0] vx;
  logic div_start;
  logic [QW-1:0] div_dvd;
  logic [VW-1:0] div_dvs;
  logic [CW-1:0] div_msb;
  logic div_done;
  logic [QW-1:0] div_q;
  logic ln_vin;
  logic [MW-1:0] ln_x;
  logic ln_vout;
  logic [LQW-1:0] ln_y;
  logic out_free;

  ntcb_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .msb      (div_msb),
    .done     (div_done),
    .quotient (div_q)
  );

  ntcb_ln u_ln (
    .clk       (clk),
    .rst       (rst),
    .valid_in  (ln_vin),
    .x         (ln_x),
    .valid_out (ln_vout),
    .y         (ln_y)
  );

  assign out_free = !out_valid || !out_stall;

  always_comb begin
    sup_ext = DW'(cfg.supply);
    d_new = (sup_ext <<< ADC_BITS) - sup_ext - q_n;
    vx = (n > 0) ? n[MW-1:0] + MW'(AMAX_HALF) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop = 1'b0;
    div_start = 1'b0;
    div_dvd = '0;
    div_dvs = VW'(AMAX);
    div_msb = '0;
    ln_vin = 1'b0;
    case (ln_idx)
      2'd0: ln_x = MW'(cfg.rs);
      2'd1: ln_x = unum;
      default: ln_x = uden;
    endcase
    case (state)
      B_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          state_next = B_VDIV;
        end
      end
      B_VDIV: begin
        state_next = B_VWAIT;
      end
      B_VWAIT: begin
        state_next = B_CLASS;
      end
      B_CLASS: begin
        if (den == 0) begin
          state_next = B_FDIV;
        end else if (num == 0 || cfg.rs == '0 || num[DW-1] != den[DW-1]) begin
          state_next = B_FDIV;
        end else begin
          state_next = B_RMUL;
        end
      end
      B_RMUL: begin
        state_next = B_RDIV;
      end
      B_RDIV: begin
        div_start = 1'b1;
        div_dvd = QW'(prod) + QW'(uden >> 1);
        div_dvs = VW'(uden);
        div_msb = CW'(QW - 1);
        state_next = B_RWAIT;
      end
      B_RWAIT: begin
        if (div_done) begin
          state_next = B_LN;
        end
      end
      B_LN: begin
        ln_vin = 1'b1;
        if (ln_idx == 2'd2) begin
          state_next = B_LWAIT;
        end
      end
      B_LWAIT: begin
        if (ln_vout && ln_got == 2'd2) begin
          state_next = B_LCHK;
        end
      end
      B_LCHK: begin
        if (lsum <= 0) begin
          state_next = B_FDIV;
        end else begin
          state_next = B_KMUL;
        end
      end
      B_KMUL: begin
        state_next = B_KDIV;
      end
      B_KDIV: begin
        div_start = 1'b1;
        div_dvd = QW'(kdvd);
        div_dvs = VW'(lsum);
        div_msb = CW'(KNW - 1);
        state_next = B_KWAIT;
      end
      B_KWAIT: begin
        if (div_done) begin
          state_next = B_FDIV;
        end
      end
      B_FDIV: begin
        state_next = B_FWAIT;
      end
      B_FWAIT: begin
        state_next = B_OUT;
      end
      B_OUT: begin
        if (out_free) begin
          state_next = B_IDLE;
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ln_vout) begin
      if (ln_got == 2'd2) begin
        lsum <= lsum - LSW'(ln_y);
      end else begin
        lsum <= lsum + LSW'(ln_y);
      end
    end
    case (state)
      B_IDLE: begin
        n <= q_n;
        num <= cfg.gnd ? q_n : d_new;
        den <= cfg.gnd ? d_new : q_n;
      end
      B_VDIV: begin
        vprod <= VPW'(vx) * VPW'(VRECIP);
      end
      B_VWAIT: begin
        vin <= (vprod[VPW-1:VRECIP_SHIFT] > (VPW - VRECIP_SHIFT)'(VIN_MAX)) ?
               14'(VIN_MAX) : vprod[VRECIP_SHIFT+13:VRECIP_SHIFT];
      end
      B_CLASS: begin
        unum <= num[DW-1] ? MW'(-num) : MW'(num);
        uden <= den[DW-1] ? MW'(-den) : MW'(den);
        kel <= 17'(KELVIN_MAX);
        if (den == 0) begin
          flt <= 1'b1;
          res <= 24'(RES_MAX);
        end else if (num == 0 || cfg.rs == '0 || num[DW-1] != den[DW-1]) begin
          flt <= 1'b1;
          res <= '0;
        end else begin
          flt <= 1'b0;
        end
      end
      B_RMUL: begin
        prod <= PW'(cfg.rs) * PW'(unum);
        lsum <= -LSW'(cfg.lri);
        ln_idx <= 2'd0;
        ln_got <= 2'd0;
      end
      B_RWAIT: begin
        if (div_done) begin
          res <= (div_q > QW'(RES_MAX)) ? 24'(RES_MAX) : div_q[23:0];
        end
      end
      B_LN: begin
        ln_idx <= ln_idx + 2'd1;
      end
      B_LCHK: begin
        if (lsum <= 0) begin
          flt <= 1'b1;
        end
      end
      B_KMUL: begin
        kdvd <= KNW'(cfg.beta) * KNW'(K_SCALE) + KNW'(lsum[LSW-1:1]);
      end
      B_KWAIT: begin
        if (div_done) begin
          kel <= (div_q > QW'(KELVIN_MAX)) ? 17'(KELVIN_MAX) : div_q[16:0];
        end
      end
      B_FDIV: begin
        fprod <= FPW'(kel) * FPW'(FRECIP_K) + FPW'(FRECIP_C);
      end
      B_FWAIT: begin
        fah <= $signed(19'(fprod[FPW-1:FRECIP_SHIFT])) - 19'sd45967;
      end
      default: begin
      end
    endcase
    if (ln_vout && state != B_RMUL) begin
      ln_got <= ln_got + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_OUT && out_free) begin
      input_mv <= vin;
      resistance_ohms <= res;
      kelvin_centi <= kel;
      celsius_centi <= $signed({1'b0, kel}) - 18'sd27315;
      fahrenheit_centi <= fah;
      fault <= flt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == B_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  a_fault_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid && fault |-> kelvin_centi == 17'(KELVIN_MAX))
    else $error("faulted item without saturated temperature");

  a_kel_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> kelvin_centi <= 17'(KELVIN_MAX))
    else $error("temperature above ceiling");

  a_celsius: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> celsius_centi == $signed({1'b0, kelvin_centi}) - 18'sd27315)
    else $error("Celsius does not track kelvin");

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> state == B_IDLE && q_valid)
    else $error("queue popped outside idle");

endmodule
`default_nettype wire

// ===== rtl/ntc_beta_temperature.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Converts one thermistor divider sample into voltage, resistance and temperature.
// The input channel takes adc_sample on in_valid when in_stall is low; a two-item
// queue behind it holds samples while the arithmetic engine is busy.
// Results leave on out_valid, held until out_stall is low, one result per item.
// The engine handles one item at a time. A fault at classification skips the
// resistance division, the logarithms and the temperature division; a log ratio
// that is not positive skips only the temperature division. One shared divider
// that produces one quotient bit per cycle serves the resistance and temperature
// divisions in turn; the voltage and Fahrenheit scalings use reciprocal
// multiplication. The output register lets the engine start the next item while
// a result waits; while the receiver stalls, the queue fills and in_stall rises.
// Registers are written through cfg_valid, cfg_index and cfg_data; cfg_ready is
// always high. The user must write only while the block is idle (not checked).
// A synchronous reset empties the queue, drops out_valid and restores the
// register reset values.
module ntc_beta_temperature
  import ntcb_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [ADC_BITS-1:0]  adc_sample,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [13:0]               input_mv,
  output logic [23:0]               resistance_ohms,
  output logic [16:0]               kelvin_centi,
  output logic signed [17:0]        celsius_centi,
  output logic signed [18:0]        fahrenheit_centi,
  output logic                      fault,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [2:0]           cfg_index,
  input  wire logic [21:0]          cfg_data
);

  cfg_t cfg;
  logic q_valid;
  logic signed [DW-1:0] q_n;
  logic q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rs <= RS_RESET;
      cfg.beta <= BETA_RESET;
      cfg.lri <= LRI_RESET;
      cfg.supply <= SUPPLY_RESET;
      cfg.ref_mv <= REF_RESET;
      cfg.ofs <= OFS_RESET;
      cfg.gnd <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_RS: cfg.rs <= cfg_data[19:0];
        REG_BETA: cfg.beta <= cfg_data[13:0];
        REG_LRI: cfg.lri <= $signed(cfg_data);
        REG_SUPPLY: cfg.supply <= cfg_data[12:0];
        REG_REF: cfg.ref_mv <= cfg_data[12:0];
        REG_OFS: cfg.ofs <= cfg_data[12:0];
        REG_GND: cfg.gnd <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  ntcb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .adc_sample (adc_sample),
    .q_valid    (q_valid),
    .q_n        (q_n),
    .q_pop      (q_pop)
  );

  ntcb_back u_back (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .q_valid          (q_valid),
    .q_n              (q_n),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .input_mv         (input_mv),
    .resistance_ohms  (resistance_ohms),
    .kelvin_centi     (kelvin_centi),
    .celsius_centi    (celsius_centi),
    .fahrenheit_centi (fahrenheit_centi),
    .fault            (fault)
  );

endmodule
`default_nettype wire

// ===== sim/ntcb_checker.sv =====
`timescale 1ns / 1ps
module ntcb_checker
  import ntcb_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic [ADC_BITS-1:0]       adc_sample,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic [13:0]               input_mv,
  input  logic [23:0]               resistance_ohms,
  input  logic [16:0]               kelvin_centi,
  input  logic signed [17:0]        celsius_centi,
  input  logic signed [18:0]        fahrenheit_centi,
  input  logic                      fault,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [2:0]                cfg_index,
  input  logic [21:0]               cfg_data,
  output int                        failures,
  output int                        outstanding
);

  typedef struct {
    logic [13:0]        mv;
    logic [23:0]        ohms;
    logic [16:0]        kel;
    logic signed [17:0] cel;
    logic signed [18:0] fah;
    logic               flt;
  } reading_t;

  localparam longint LOG_STEPS [0:16] = '{
    0, 3973, 7719, 11262, 14624, 17821, 20870, 23783, 26573,
    29248, 31818, 34292, 36675, 38975, 41196, 43345, 45426
  };

  cfg_t setting;
  reading_t pending_readings[$];

  function automatic longint log_q16(longint unsigned x);
    int e;
    logic [63:0] f;
    int i;
    longint r;
    e = 63;
    while (e > 0 && !x[e]) e--;
    f = (64'(x) << (63 - e)) << 1;
    i = f[63:60];
    r = f[59:44];
    return longint'(e) * LN2_Q16 + LOG_STEPS[i]
      + (((LOG_STEPS[i + 1] - LOG_STEPS[i]) * r + 32768) >>> 16);
  endfunction

  function automatic reading_t convert_sample(logic [ADC_BITS-1:0] s);
    reading_t res;
    longint amax, n, d, num, den, vin, kel, l, t, r;
    longint unsigned unum, uden;
    logic flt;
    amax = AMAX;
    n = longint'(setting.ofs) * amax
      + longint'(s) * (longint'(setting.ref_mv) - longint'(setting.ofs));
    d = longint'(setting.supply) * amax - n;
    num = setting.gnd ? n : d;
    den = setting.gnd ? d : n;
    kel = KELVIN_MAX;
    flt = 1'b0;
    r = 0;
    vin = (n <= 0) ? 0 : (n + amax / 2) / amax;
    if (vin > VIN_MAX) vin = VIN_MAX;
    if (den == 0) begin
      flt = 1'b1;
      r = RES_MAX;
    end else if (num == 0 || setting.rs == 0 || ((num < 0) != (den < 0))) begin
      flt = 1'b1;
      r = 0;
    end else begin
      unum = (num < 0) ? -num : num;
      uden = (den < 0) ? -den : den;
      r = (longint'(setting.rs) * unum + uden / 2) / uden;
      if (r > RES_MAX) r = RES_MAX;
      l = log_q16(setting.rs) + log_q16(unum) - log_q16(uden) - longint'(setting.lri);
      if (l <= 0) begin
        flt = 1'b1;
      end else begin
        t = (longint'(setting.beta) * K_SCALE + l / 2) / l;
        kel = (t > KELVIN_MAX) ? KELVIN_MAX : t;
      end
    end
    if (flt) kel = KELVIN_MAX;
    res.mv = vin[13:0];
    res.ohms = r[23:0];
    res.kel = kel[16:0];
    res.cel = 18'(kel - CELSIUS_OFS);
    res.fah = 19'((18 * kel + 5) / 10 - FAHR_OFS);
    res.flt = flt;
    return res;
  endfunction

  task automatic compare_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      failures++;
    end
  endtask

  initial begin
    failures = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin
    reading_t want;
    if (rst) begin
      setting.rs <= RS_RESET;
      setting.beta <= BETA_RESET;
      setting.lri <= LRI_RESET;
      setting.supply <= SUPPLY_RESET;
      setting.ref_mv <= REF_RESET;
      setting.ofs <= OFS_RESET;
      setting.gnd <= 1'b1;
      pending_readings.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (reg_idx_t'(cfg_index))
          REG_RS:     setting.rs <= cfg_data[19:0];
          REG_BETA:   setting.beta <= cfg_data[13:0];
          REG_LRI:    setting.lri <= cfg_data;
          REG_SUPPLY: setting.supply <= cfg_data[12:0];
          REG_REF:    setting.ref_mv <= cfg_data[12:0];
          REG_OFS:    setting.ofs <= cfg_data[12:0];
          REG_GND:    setting.gnd <= cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) pending_readings.push_back(convert_sample(adc_sample));
      if (out_valid && !out_stall) begin
        if (pending_readings.size() == 0) begin
          $error("result item arrived with no sample outstanding");
          failures++;
        end else begin
          want = pending_readings.pop_front();
          compare_field("input_mv", want.mv, input_mv);
          compare_field("resistance_ohms", want.ohms, resistance_ohms);
          compare_field("kelvin_centi", want.kel, kelvin_centi);
          compare_field("celsius_centi", want.cel, celsius_centi);
          compare_field("fahrenheit_centi", want.fah, fahrenheit_centi);
          compare_field("fault", want.flt, fault);
        end
      end
    end
    outstanding <= pending_readings.size();
  end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import ntcb_pkg::*;

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall;
  logic [ADC_BITS-1:0] adc_sample;
  logic [13:0] input_mv;
  logic [23:0] resistance_ohms;
  logic [16:0] kelvin_centi;
  logic signed [17:0] celsius_centi;
  logic signed [18:0] fahrenheit_centi;
  logic fault;
  logic cfg_valid, cfg_ready;
  logic [2:0] cfg_index;
  logic [21:0] cfg_data;
  int failures, outstanding;
  int gap_pct, stall_pct;
  logic hold_request;

  ntc_beta_temperature uut (.*);

  ntcb_checker monitor (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #40ms;
    $display("ntc_beta_temperature verification failed");
    $finish;
  end

  initial begin
    int held;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_stall = 1'b1;
        for (held = 0; held < 400; held++) @(negedge clk);
        hold_request = 1'b0;
      end
      out_stall = ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_sample(logic [ADC_BITS-1:0] s);
    while ($urandom_range(99) < gap_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    adc_sample = s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain;
    in_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [21:0] value);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic load_setting(logic [19:0] rs, logic [13:0] beta, logic [21:0] lri,
                              logic [12:0] sup, logic [12:0] refv, logic [12:0] ofs,
                              logic gnd);
    drain();
    write_reg(REG_RS, 22'(rs));
    write_reg(REG_BETA, 22'(beta));
    write_reg(REG_LRI, lri);
    write_reg(REG_SUPPLY, 22'(sup));
    write_reg(REG_REF, 22'(refv));
    write_reg(REG_OFS, 22'(ofs));
    write_reg(REG_GND, 22'(gnd));
  endtask

  task automatic random_setting;
    logic [12:0] v;
    if ($urandom_range(3) != 0) begin
      v = 13'($urandom_range(1800, 5500));
      load_setting(20'($urandom_range(1000, 200000)), 14'($urandom_range(1000, 10000)),
                   22'(-$urandom_range(150000, 450000)), v,
                   ($urandom_range(1) != 0) ? v : 13'($urandom_range(1000, 5500)),
                   13'($urandom_range(0, 300)), 1'($urandom_range(1)));
    end else begin
      load_setting(20'($urandom), 14'($urandom), 22'($urandom), 13'($urandom),
                   13'($urandom), 13'($urandom), 1'($urandom));
    end
  endtask

  task automatic edge_samples;
    send_sample(12'd0);
    send_sample(12'd1);
    send_sample(12'd2047);
    send_sample(12'd2048);
    send_sample(12'd4094);
    send_sample(12'd4095);
  endtask

  initial begin
    int phase, k;
    rst = 1'b1;
    in_valid = 1'b0;
    adc_sample = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    gap_pct = 0;
    stall_pct = 0;
    hold_request = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    edge_samples();
    load_setting(20'd1, 14'd1000, -22'sd1966080, 13'd0, 13'd5500, 13'd0, 1'b1);
    edge_samples();
    load_setting(20'd1000000, 14'd10000, 22'sd655360, 13'd5500, 13'd5500, 13'd5500, 1'b0);
    edge_samples();
    load_setting(20'hFFFFF, 14'h3FFF, 22'h1FFFFF, 13'h1FFF, 13'd3000, 13'd4000, 1'b0);
    edge_samples();
    load_setting(RS_RESET, BETA_RESET, LRI_RESET, SUPPLY_RESET, REF_RESET, OFS_RESET, 1'b1);

    for (phase = 0; phase < 4; phase++) begin
      gap_pct = (phase == 1) ? 61 : (phase == 3) ? 38 : 0;
      stall_pct = (phase == 2) ? 61 : (phase == 3) ? 38 : 0;
      for (k = 0; k < 175; k++) begin
        if (k % 35 == 0) random_setting();
        if (phase == 2 && k == 50) hold_request = 1'b1;
        send_sample(ADC_BITS'($urandom));
      end
    end

    drain();
    if (failures == 0 && outstanding == 0) begin
      $display("ntc_beta_temperature verification clean");
    end else begin
      $display("ntc_beta_temperature verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ntcb_pkg.sv
rtl/ntcb_front.sv
rtl/ntcb_div.sv
rtl/ntcb_ln.sv
rtl/ntcb_back.sv
rtl/ntc_beta_temperature.sv
sim/ntcb_checker.sv
sim/testbench.sv
